@@ design/smpte_tc_pkg.sv @@
// ----------------------------------------------------------------------------
// SMPTE timecode counter package
// Widths, register indexes, rate mode codes, handshake structs and rate
// helpers shared by the counter modules.
// ----------------------------------------------------------------------------
package smpte_tc_pkg;

  localparam int unsigned CountW  = 14;
  localparam int unsigned DvdW    = 15;
  localparam int unsigned DivW    = 8;
  localparam int unsigned FrameW  = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned MinW    = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned AccW    = 15;
  localparam int unsigned StepW   = 4;
  localparam int unsigned ModeW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  localparam logic [CfgIdxW-1:0] CfgRateMode = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSubDiv   = CfgIdxW'(1);

  localparam logic [ModeW-1:0] Mode24     = ModeW'(0);
  localparam logic [ModeW-1:0] Mode2398   = ModeW'(1);
  localparam logic [ModeW-1:0] Mode25     = ModeW'(2);
  localparam logic [ModeW-1:0] Mode30     = ModeW'(3);
  localparam logic [ModeW-1:0] Mode30Df   = ModeW'(4);
  localparam logic [ModeW-1:0] Mode2997   = ModeW'(5);
  localparam logic [ModeW-1:0] Mode2997Df = ModeW'(6);
  localparam logic [ModeW-1:0] Mode60     = ModeW'(7);
  localparam logic [ModeW-1:0] Mode5994   = ModeW'(8);
  localparam logic [ModeW-1:0] Mode60Df   = ModeW'(9);
  localparam logic [ModeW-1:0] Mode5994Df = ModeW'(10);
  localparam logic [ModeW-1:0] Mode50     = ModeW'(11);

  localparam logic [SecW-1:0]  SecMax     = SecW'(59);
  localparam logic [MinW-1:0]  MinMax     = MinW'(59);
  localparam logic [HourW-1:0] HourMax    = HourW'(23);
  localparam logic [AccW-1:0]  DropFrames = AccW'(2);
  localparam logic [StepW-1:0] DivSteps   = StepW'(DvdW - 1);

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
    logic [DivW-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [AccW-1:0]   frame_add;
    logic [FrameW-1:0] rate;
    logic              drops;
  } carry_req_t;

  typedef struct packed {
    logic              done;
    logic [HourW-1:0]  hours;
    logic [MinW-1:0]   minutes;
    logic [SecW-1:0]   seconds;
    logic [FrameW-1:0] frames;
  } carry_rsp_t;

  function automatic logic [FrameW-1:0] rate_of_mode(input logic [ModeW-1:0] mode);
    logic [FrameW-1:0] rate;
    unique case (mode)
      Mode25:                                  rate = FrameW'(25);
      Mode30, Mode30Df, Mode2997, Mode2997Df:  rate = FrameW'(30);
      Mode60, Mode5994, Mode60Df, Mode5994Df:  rate = FrameW'(60);
      Mode50:                                  rate = FrameW'(50);
      default:                                 rate = FrameW'(24);
    endcase
    return rate;
  endfunction

  function automatic logic mode_drops(input logic [ModeW-1:0] mode);
    return (mode == Mode30Df) || (mode == Mode2997Df) ||
           (mode == Mode60Df) || (mode == Mode5994Df);
  endfunction

  function automatic logic minute_is_tenth(input logic [MinW-1:0] m);
    return (m == MinW'(0))  || (m == MinW'(10)) || (m == MinW'(20)) ||
           (m == MinW'(30)) || (m == MinW'(40)) || (m == MinW'(50));
  endfunction

endpackage

@@ design/smpte_timecode_counter.sv @@
// ----------------------------------------------------------------------------
// SMPTE timecode counter
// Adds subframe or frame counts to an hh:mm:ss:ff.sf timecode with
// drop-frame support.
// Items pass through the divider, then the carry loop, which carries one
// second per cycle, then the output register. One item at a time: a new
// item is refused until the last result is loaded into the output register.
// The next item is taken while the last result waits in the output register.
// Reset: timecode zero, rate mode 0 (24 fps), subframe divisor 1.
// ----------------------------------------------------------------------------
module smpte_timecode_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [smpte_tc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [smpte_tc_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [smpte_tc_pkg::CountW-1:0]     add_count_i,
  input  logic                                unit_is_frame_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [smpte_tc_pkg::HourW-1:0]      hours_out_o,
  output logic [smpte_tc_pkg::MinW-1:0]       minutes_out_o,
  output logic [smpte_tc_pkg::SecW-1:0]       seconds_out_o,
  output logic [smpte_tc_pkg::FrameW-1:0]     frames_out_o,
  output logic [smpte_tc_pkg::DivW-1:0]       subframes_out_o,
  output logic                                drop_mode_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDiv   = 2'd1;
  localparam logic [1:0] StCarry = 2'd2;
  localparam logic [1:0] StPush  = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [smpte_tc_pkg::ModeW-1:0]    rate_mode_q;
  logic [smpte_tc_pkg::DivW-1:0]     sub_div_q;
  logic [smpte_tc_pkg::DivW-1:0]     sub_q;
  logic [smpte_tc_pkg::CountW-1:0]   count_q;
  logic                              as_frames_q;
  logic                              out_valid_q;
  logic [smpte_tc_pkg::HourW-1:0]    hours_q;
  logic [smpte_tc_pkg::MinW-1:0]     minutes_q;
  logic [smpte_tc_pkg::SecW-1:0]     seconds_q;
  logic [smpte_tc_pkg::FrameW-1:0]   frames_q;
  logic [smpte_tc_pkg::DivW-1:0]     subframes_q;
  logic                              drop_q;
  logic                              in_beat;
  logic                              out_free;
  logic [smpte_tc_pkg::DivW-1:0]     div_eff;
  smpte_tc_pkg::div_req_t            div_req;
  smpte_tc_pkg::div_rsp_t            div_rsp;
  smpte_tc_pkg::carry_req_t          carry_req;
  smpte_tc_pkg::carry_rsp_t          carry_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != StIdle;
  assign in_beat     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign div_eff     = (sub_div_q == '0) ? smpte_tc_pkg::DivW'(1) : sub_div_q;

  always_comb begin
    div_req.start    = in_beat;
    div_req.divisor  = div_eff;
    div_req.dividend = unit_is_frame_i
                     ? smpte_tc_pkg::DvdW'(sub_q)
                     : smpte_tc_pkg::DvdW'(sub_q) + smpte_tc_pkg::DvdW'(add_count_i);

    carry_req.start     = (state_q == StDiv) && div_rsp.done;
    carry_req.frame_add = div_rsp.quotient
                        + (as_frames_q ? smpte_tc_pkg::AccW'(count_q) : '0);
    carry_req.rate      = smpte_tc_pkg::rate_of_mode(rate_mode_q);
    carry_req.drops     = smpte_tc_pkg::mode_drops(rate_mode_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_beat)        state_d = StDiv;
      StDiv:   if (div_rsp.done)   state_d = StCarry;
      StCarry: if (carry_rsp.done) state_d = StPush;
      StPush:  if (out_free)       state_d = StIdle;
      default:                     state_d = StIdle;
    endcase
  end

  smpte_tc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  smpte_tc_carry u_carry (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (carry_req),
    .rsp_o  (carry_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rate_mode_q <= smpte_tc_pkg::Mode24;
      sub_div_q   <= smpte_tc_pkg::DivW'(1);
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          smpte_tc_pkg::CfgRateMode: rate_mode_q <= cfg_data_i[smpte_tc_pkg::ModeW-1:0];
          smpte_tc_pkg::CfgSubDiv:   sub_div_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (carry_req.start) begin
        sub_q <= div_rsp.remainder;
      end
      if (state_q == StPush && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      count_q     <= add_count_i;
      as_frames_q <= unit_is_frame_i;
    end
    if (state_q == StPush && out_free) begin
      hours_q     <= carry_rsp.hours;
      minutes_q   <= carry_rsp.minutes;
      seconds_q   <= carry_rsp.seconds;
      frames_q    <= carry_rsp.frames;
      subframes_q <= sub_q;
      drop_q      <= smpte_tc_pkg::mode_drops(rate_mode_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hours_out_o     = hours_q;
  assign minutes_out_o   = minutes_q;
  assign seconds_out_o   = seconds_q;
  assign frames_out_o    = frames_q;
  assign subframes_out_o = subframes_q;
  assign drop_mode_o     = drop_q;

endmodule

@@ design/smpte_tc_div.sv @@
// ----------------------------------------------------------------------------
// SMPTE timecode serial divider
// Restoring divider, one quotient bit per cycle, splitting a count into
// frames and the subframe remainder.
// ----------------------------------------------------------------------------
module smpte_tc_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smpte_tc_pkg::div_req_t req_i,
  output smpte_tc_pkg::div_rsp_t rsp_o
);

  logic [smpte_tc_pkg::DvdW-1:0]  dvd_q, dvd_d;
  logic [smpte_tc_pkg::DivW-1:0]  rem_q, rem_d;
  logic [smpte_tc_pkg::DivW-1:0]  dsr_q;
  logic [smpte_tc_pkg::StepW-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [smpte_tc_pkg::DivW:0]    trial;
  logic                           fits;

  always_comb begin
    trial = {rem_q, dvd_q[smpte_tc_pkg::DvdW-1]};
    fits  = trial >= {1'b0, dsr_q};
    rem_d = fits ? smpte_tc_pkg::DivW'(trial - {1'b0, dsr_q})
                 : trial[smpte_tc_pkg::DivW-1:0];
    dvd_d = {dvd_q[smpte_tc_pkg::DvdW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == smpte_tc_pkg::DivSteps);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + smpte_tc_pkg::StepW'(1);
        if (cnt_q == smpte_tc_pkg::DivSteps) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule

@@ design/smpte_tc_carry.sv @@
// ----------------------------------------------------------------------------
// SMPTE timecode carry sequencer
// Holds frames, seconds, minutes and hours; carries one second per cycle
// and applies the drop-frame rule at each minute boundary.
// ----------------------------------------------------------------------------
module smpte_tc_carry (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  smpte_tc_pkg::carry_req_t req_i,
  output smpte_tc_pkg::carry_rsp_t rsp_o
);

  logic [smpte_tc_pkg::AccW-1:0]   acc_q, acc_d;
  logic [smpte_tc_pkg::SecW-1:0]   sec_q, sec_d;
  logic [smpte_tc_pkg::MinW-1:0]   min_q, min_d;
  logic [smpte_tc_pkg::HourW-1:0]  hour_q, hour_d;
  logic [smpte_tc_pkg::FrameW-1:0] rate_q;
  logic                            drops_q;
  logic                            busy_q;
  logic                            done_q;
  logic                            sec_wrap;
  logic                            min_wrap;
  logic                            drop;
  logic                            over;

  always_comb begin
    sec_wrap = sec_q == smpte_tc_pkg::SecMax;
    min_wrap = min_q == smpte_tc_pkg::MinMax;
    sec_d    = sec_wrap ? '0 : sec_q + smpte_tc_pkg::SecW'(1);
    min_d    = min_q;
    hour_d   = hour_q;
    if (sec_wrap) begin
      min_d = min_wrap ? '0 : min_q + smpte_tc_pkg::MinW'(1);
      if (min_wrap) begin
        hour_d = (hour_q == smpte_tc_pkg::HourMax) ? '0 : hour_q + smpte_tc_pkg::HourW'(1);
      end
    end
    drop  = drops_q && sec_wrap && !smpte_tc_pkg::minute_is_tenth(min_d);
    over  = acc_q >= smpte_tc_pkg::AccW'(rate_q);
    acc_d = acc_q - smpte_tc_pkg::AccW'(rate_q) + (drop ? smpte_tc_pkg::DropFrames : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      rate_q  <= '0;
      drops_q <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= !req_i.start && busy_q && !over;
      if (req_i.start) begin
        acc_q   <= acc_q + req_i.frame_add;
        rate_q  <= req_i.rate;
        drops_q <= req_i.drops;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        if (over) begin
          acc_q  <= acc_d;
          sec_q  <= sec_d;
          min_q  <= min_d;
          hour_q <= hour_d;
        end else begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.hours   = hour_q;
  assign rsp_o.minutes = min_q;
  assign rsp_o.seconds = sec_q;
  assign rsp_o.frames  = acc_q[smpte_tc_pkg::FrameW-1:0];

endmodule

@@ design/smpte_tc_checker.sv @@
// ----------------------------------------------------------------------------
// SMPTE timecode counter port checker
// Port-level properties of the counter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module smpte_tc_sva (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [smpte_tc_pkg::HourW-1:0]      hours_out_o,
  input logic [smpte_tc_pkg::MinW-1:0]       minutes_out_o,
  input logic [smpte_tc_pkg::SecW-1:0]       seconds_out_o,
  input logic [smpte_tc_pkg::FrameW-1:0]     frames_out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the item finished");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hours_out_o <= smpte_tc_pkg::HourMax &&
                    minutes_out_o <= smpte_tc_pkg::MinMax &&
                    seconds_out_o <= smpte_tc_pkg::SecMax)
    else $error("timecode field out of range");

  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frames_out_o < smpte_tc_pkg::FrameW'(60))
    else $error("frame number out of range");

endmodule

bind smpte_timecode_counter smpte_tc_sva u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .hours_out_o   (hours_out_o),
  .minutes_out_o (minutes_out_o),
  .seconds_out_o (seconds_out_o),
  .frames_out_o  (frames_out_o)
);

@@ dv/smpte_tc_checker.sv @@
// ----------------------------------------------------------------------------
// SMPTE timecode counter checker
// Watches the configuration, input and result channels of the counter,
// keeps its own timecode and register copies, predicts the timecode for
// every input beat and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------
module smpte_tc_checker
  import smpte_tc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [CountW-1:0]   add_count_i,
  input  logic                unit_is_frame_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [HourW-1:0]    hours_i,
  input  logic [MinW-1:0]     minutes_i,
  input  logic [SecW-1:0]     seconds_i,
  input  logic [FrameW-1:0]   frames_i,
  input  logic [DivW-1:0]     subframes_i,
  input  logic                drop_mode_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         checked_o,
  output int unsigned         wraps_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportMax = 40;

  typedef struct packed {
    logic [HourW-1:0]  hours;
    logic [MinW-1:0]   minutes;
    logic [SecW-1:0]   seconds;
    logic [FrameW-1:0] frames;
    logic [DivW-1:0]   subframes;
    logic              drop;
  } timecode_t;

  logic [ModeW-1:0] rate_mode_q = Mode24;
  logic [DivW-1:0]  sub_div_q = DivW'(1);
  int unsigned      tc_sub = 0;
  int unsigned      tc_frame = 0;
  int unsigned      tc_sec = 0;
  int unsigned      tc_min = 0;
  int unsigned      tc_hour = 0;
  int unsigned      n_fail = 0;
  int unsigned      n_checked = 0;
  int unsigned      n_wraps = 0;
  timecode_t        due_timecodes[$];

  function automatic int unsigned frames_per_sec(input logic [ModeW-1:0] mode);
    int unsigned fps;
    case (mode)
      Mode25: fps = 25;
      Mode30, Mode30Df, Mode2997, Mode2997Df: fps = 30;
      Mode60, Mode5994, Mode60Df, Mode5994Df: fps = 60;
      Mode50: fps = 50;
      default: fps = 24;
    endcase
    return fps;
  endfunction

  function automatic logic drops_frames(input logic [ModeW-1:0] mode);
    return mode inside {Mode30Df, Mode2997Df, Mode60Df, Mode5994Df};
  endfunction

  // Advance one second; in drop-frame modes drop two frame labels entering a non-tenth minute.
  function automatic void tick_second();
    if (tc_sec < SecMax) begin
      tc_sec++;
    end else begin
      tc_sec = 0;
      if (tc_min < MinMax) begin
        tc_min++;
      end else begin
        tc_min = 0;
        if (tc_hour < HourMax) begin
          tc_hour++;
        end else begin
          tc_hour = 0;
          n_wraps++;
        end
      end
      if (drops_frames(rate_mode_q) && (tc_min % 10) != 0) begin
        tc_frame += DropFrames;
      end
    end
  endfunction

  function automatic timecode_t advance_timecode(input logic [CountW-1:0] amount,
                                                 input logic as_frames);
    int unsigned div;
    int unsigned fps;
    int unsigned frame_add;
    int unsigned sum;
    timecode_t   tc;
    div = (sub_div_q == '0) ? 1 : sub_div_q;
    fps = frames_per_sec(rate_mode_q);
    if (as_frames) begin
      frame_add = amount;
      sum = tc_sub;
    end else begin
      frame_add = amount / div;
      sum = tc_sub + amount % div;
    end
    frame_add += sum / div;
    tc_sub = sum % div;
    tc_frame += frame_add;
    while (tc_frame >= fps) begin
      tc_frame -= fps;
      tick_second();
    end
    tc.hours     = HourW'(tc_hour);
    tc.minutes   = MinW'(tc_min);
    tc.seconds   = SecW'(tc_sec);
    tc.frames    = FrameW'(tc_frame);
    tc.subframes = DivW'(tc_sub);
    tc.drop      = drops_frames(rate_mode_q);
    return tc;
  endfunction

  task automatic report_mismatch(input string msg);
    if (n_fail < ReportMax) begin
      $display("%0t checker: %s", $realtime, msg);
    end
    n_fail++;
  endtask

  task automatic compare_result();
    timecode_t want;
    if (due_timecodes.size() == 0) begin
      report_mismatch($sformatf("unexpected result %0d:%0d:%0d:%0d.%0d", hours_i,
                                minutes_i, seconds_i, frames_i, subframes_i));
    end else begin
      want = due_timecodes.pop_front();
      n_checked++;
      if (hours_i !== want.hours) begin
        report_mismatch($sformatf("hours got %0d, expected %0d", hours_i, want.hours));
      end
      if (minutes_i !== want.minutes) begin
        report_mismatch($sformatf("minutes got %0d, expected %0d", minutes_i, want.minutes));
      end
      if (seconds_i !== want.seconds) begin
        report_mismatch($sformatf("seconds got %0d, expected %0d", seconds_i, want.seconds));
      end
      if (frames_i !== want.frames) begin
        report_mismatch($sformatf("frames got %0d, expected %0d", frames_i, want.frames));
      end
      if (subframes_i !== want.subframes) begin
        report_mismatch($sformatf("subframes got %0d, expected %0d", subframes_i,
                                  want.subframes));
      end
      if (drop_mode_i !== want.drop) begin
        report_mismatch($sformatf("drop mode got %0d, expected %0d", drop_mode_i, want.drop));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_mode_q = Mode24;
      sub_div_q   = DivW'(1);
      tc_sub      = 0;
      tc_frame    = 0;
      tc_sec      = 0;
      tc_min      = 0;
      tc_hour     = 0;
      due_timecodes.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgRateMode: rate_mode_q = cfg_data_i[ModeW-1:0];
          CfgSubDiv:   sub_div_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        compare_result();
      end
      if (in_valid_i && !in_stall_i) begin
        due_timecodes.push_back(advance_timecode(add_count_i, unit_is_frame_i));
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= due_timecodes.size();
    checked_o    <= n_checked;
    wraps_o      <= n_wraps;
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// SMPTE timecode counter testbench
// Directed beats for drop frames, large carries, zero and extreme divisors
// and spare rate modes, then random phases over every rate mode and several
// divisors with sender and receiver idling, and a long run past midnight.
// ----------------------------------------------------------------------------
module tb;
  import smpte_tc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit    = 20000;
  localparam int unsigned PhaseBeats    = 56;
  localparam int unsigned MidnightBeats = 180;
  localparam int unsigned MaxAdd        = 15299;
  localparam logic [ModeW-1:0] ModeSpare = ModeW'(15);

  typedef enum int unsigned {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_profile_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgRateMode;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CountW-1:0]   add_count_i = '0;
  logic                unit_is_frame_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [HourW-1:0]    hours_out_o;
  logic [MinW-1:0]     minutes_out_o;
  logic [SecW-1:0]     seconds_out_o;
  logic [FrameW-1:0]   frames_out_o;
  logic [DivW-1:0]     subframes_out_o;
  logic                drop_mode_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned wraps;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned beats_sent = 0;
  int unsigned quiet_cycles = 0;

  smpte_timecode_counter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .add_count_i    (add_count_i),
    .unit_is_frame_i(unit_is_frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hours_out_o    (hours_out_o),
    .minutes_out_o  (minutes_out_o),
    .seconds_out_o  (seconds_out_o),
    .frames_out_o   (frames_out_o),
    .subframes_out_o(subframes_out_o),
    .drop_mode_o    (drop_mode_o)
  );

  smpte_tc_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .add_count_i    (add_count_i),
    .unit_is_frame_i(unit_is_frame_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hours_i        (hours_out_o),
    .minutes_i      (minutes_out_o),
    .seconds_i      (seconds_out_o),
    .frames_i       (frames_out_o),
    .subframes_i    (subframes_out_o),
    .drop_mode_i    (drop_mode_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .wraps_o        (wraps)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t watchdog: no beat for %0d cycles", $realtime, quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input idle_profile_e profile);
    case (profile)
      IdleNone: begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      IdleSender: begin
        send_gap_pct = 47;
        recv_stall_pct = 0;
      end
      IdleReceiver: begin
        send_gap_pct = 0;
        recv_stall_pct = 47;
      end
      default: begin
        send_gap_pct = 35;
        recv_stall_pct = 35;
      end
    endcase
  endtask

  task automatic send_beat(input logic [CountW-1:0] amount, input logic as_frames);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    add_count_i     <= amount;
    unit_is_frame_i <= as_frames;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // Hold the sender until every predicted timecode has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic configure(input logic [ModeW-1:0] mode, input logic [DivW-1:0] div);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgRateMode;
    cfg_data_i  <= CfgW'(mode);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgSubDiv;
    cfg_data_i  <= div;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_beat(input logic [DivW-1:0] div);
    int unsigned sel;
    int unsigned span;
    int unsigned bit_pos;
    sel = $urandom_range(99);
    span = ((div == '0) ? 1 : div) * 30;
    if (sel < 50) begin
      send_beat(CountW'($urandom_range(span - 1, 0)), 1'b0);
    end else if (sel < 70) begin
      send_beat(CountW'($urandom_range(90, 0)), 1'b1);
    end else if (sel < 88) begin
      send_beat(CountW'($urandom_range(MaxAdd, 0)), 1'($urandom_range(1)));
    end else begin
      bit_pos = $urandom_range(CountW + 1, 0);
      if (bit_pos == CountW) begin
        send_beat('0, 1'($urandom_range(1)));
      end else if (bit_pos > CountW) begin
        send_beat(CountW'(MaxAdd), 1'($urandom_range(1)));
      end else begin
        send_beat(CountW'(1) << bit_pos, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin : stimulus
    logic [DivW-1:0] div;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(IdleNone);
    send_beat('0, 1'b0);
    send_beat(CountW'(MaxAdd), 1'b0);
    configure(Mode30Df, DivW'(1));
    send_beat(CountW'(1798), 1'b1);
    send_beat(CountW'(30), 1'b1);
    send_beat(CountW'(1769), 1'b1);
    send_beat(CountW'(1), 1'b1);
    send_beat(CountW'(MaxAdd), 1'b1);
    configure(ModeSpare, DivW'(0));
    send_beat(CountW'(5), 1'b0);
    send_beat(CountW'(23), 1'b1);
    configure(Mode50, DivW'(255));
    send_beat(CountW'(MaxAdd), 1'b0);
    send_beat(CountW'(254), 1'b0);
    send_beat(CountW'(1), 1'b0);
    send_beat(CountW'(3), 1'b1);
    configure(Mode60, DivW'(7));
    send_beat('0, 1'b0);
    send_beat(CountW'(14'h2AAA), 1'b1);
    send_beat(CountW'(14'h1555), 1'b0);
    configure(Mode25, DivW'(255));
    send_beat('0, 1'b1);

    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: div = DivW'(1);
        1: div = DivW'(255);
        2: div = (p == 2) ? DivW'(0) : DivW'($urandom_range(254, 2));
        default: div = DivW'($urandom_range(255, 1));
      endcase
      configure(ModeW'(p), div);
      set_idling(idle_profile_e'(p % 4));
      send_beat('0, 1'($urandom_range(1)));
      for (int i = 1; i < PhaseBeats; i++) begin
        if (i == PhaseBeats / 2) drain_results();
        random_beat(div);
      end
    end

    configure(Mode2997Df, DivW'($urandom_range(255, 1)));
    set_idling(IdleBoth);
    repeat (MidnightBeats) send_beat(CountW'($urandom_range(MaxAdd, 15000)), 1'b1);

    drain_results();
    set_idling(IdleNone);
    repeat (50) @(posedge clk_i);
    $display("tb summary: %0d input beats, %0d timecodes compared over all 16 rate modes",
             beats_sent, checked);
    $display("tb summary: divisors 0, 1, 255 and random, four idle profiles, %0d midnight wraps",
             wraps);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
